### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the swerve kinematics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SWIK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/swik_pkg.sv
// ----------------------------------------------------------------------------
// swik_pkg
// Widths, codes, constants and tables of the swerve inverse kinematics block.
// ----------------------------------------------------------------------------
package swik_pkg;

	// module count and table depth
	localparam int NUM_MODULES = 4;
	localparam int MOD_DEPTH   = 4;
	localparam int MOD_IDX_W   = 2;
	localparam logic [MOD_IDX_W-1:0] LAST_MOD = MOD_IDX_W'(NUM_MODULES - 1);

	// modules that subtract the yaw term
	localparam logic [MOD_IDX_W-1:0] YAW_SUB_MOD_A = 2'd0;
	localparam logic [MOD_IDX_W-1:0] YAW_SUB_MOD_B = 2'd3;

	// field widths
	localparam int VEL_W   = 16;
	localparam int SPEED_W = 24;
	localparam int ANGLE_W = 32;
	localparam int OFFS_W  = 32;
	localparam int SCALE_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULE0_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULE3_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd4;
	localparam logic [SCALE_W-1:0]   SPEED_SCALE_RESET  = 16'd256;

	// vector, cordic and sqrt datapath
	localparam int VEC_W   = 32;
	localparam int CRD_W   = 36;
	localparam int ACC_W   = 26;
	localparam int CORDIC_ITERS = 16;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 34;
	localparam int SQRT_STEPS_PER_CYCLE = 2;
	localparam int SQRT_CYCLES = RAD_W / (2 * SQRT_STEPS_PER_CYCLE);

	localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 26'sd8388608;
	localparam logic signed [ACC_W-1:0] ACC_ROUND     = 26'sd128;

	// turn rule, in 65536 counts per turn
	localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
	localparam logic signed [16:0] HALF_TURN    = 17'sd32768;

	// speed rounding and saturation
	localparam logic [47:0] SPD_ROUND = 48'd536870912;
	localparam logic signed [SPEED_W:0] SPD_MAX = 25'sd8388607;
	localparam logic signed [SPEED_W:0] SPD_MIN = -25'sd8388608;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_MULX,
		S_MULY,
		S_SQX,
		S_SQY,
		S_SUM,
		S_SQRT,
		S_WAIT,
		S_SCALE,
		S_TURN,
		S_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_NORM,
		CS_ITER
	} cordic_state_t;

	// arctangent of 2^-i in 2^-24 turn
	function automatic logic [21:0] atan_lut(input logic [3:0] i);
		logic [21:0] v;
		case (i)
			4'd0:    v = 22'd2097152;
			4'd1:    v = 22'd1238021;
			4'd2:    v = 22'd654136;
			4'd3:    v = 22'd332050;
			4'd4:    v = 22'd166669;
			4'd5:    v = 22'd83416;
			4'd6:    v = 22'd41718;
			4'd7:    v = 22'd20860;
			4'd8:    v = 22'd10430;
			4'd9:    v = 22'd5215;
			4'd10:   v = 22'd2608;
			4'd11:   v = 22'd1304;
			4'd12:   v = 22'd652;
			4'd13:   v = 22'd326;
			4'd14:   v = 22'd163;
			4'd15:   v = 22'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/swik_if.sv
// ----------------------------------------------------------------------------
// swik_if
// Valid/ready channels of the swerve kinematics block: command, result, config.
// ----------------------------------------------------------------------------
interface swik_cmd_if;
	logic valid;
	logic ready;
	logic signed [swik_pkg::VEL_W-1:0] vel_x;
	logic signed [swik_pkg::VEL_W-1:0] vel_y;
	logic signed [swik_pkg::VEL_W-1:0] yaw_rate;

	modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
	modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface swik_res_if;
	logic valid;
	logic ready;
	logic [swik_pkg::MOD_IDX_W-1:0]      module_index;
	logic signed [swik_pkg::SPEED_W-1:0] drive_speed;
	logic signed [swik_pkg::ANGLE_W-1:0] steer_angle;
	logic                                last;

	modport source (output valid, output module_index, output drive_speed,
		output steer_angle, output last, input ready);
	modport sink   (input valid, input module_index, input drive_speed,
		input steer_angle, input last, output ready);
endinterface

interface swik_cfg_if;
	logic valid;
	logic ready;
	logic [swik_pkg::CFG_IDX_W-1:0]  index;
	logic [swik_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/swerve_module_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// swerve_module_inverse_kinematics_unit
// Turns one chassis velocity command (vel_x, vel_y, yaw_rate) into four result
// words, one per swerve module in module order, the last flagged by last. Each
// word carries the saturated wheel speed and the multi-turn steering angle; a
// turn of a quarter turn or more is taken the short way with the speed negated,
// and a zero module vector gives speed 0 with the angle kept. Module positions
// live in a small RAM written through the config channel, the held angles in a
// second RAM that is read, updated and written back per module. Modules are
// worked one at a time; a module with a zero vector skips the CORDIC and the
// square root. The CORDIC unit normalizes the vector and then runs sixteen
// rotations, one a cycle, with the square root running beside it. A new
// command is taken once the last module's word sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swerve_module_inverse_kinematics_unit (
	input  logic       clk,
	input  logic       arst_n,
	swik_cmd_if.sink   cmd,
	swik_res_if.source res,
	swik_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_YAW_X,
		MUL_YAW_Y,
		MUL_SQ_X,
		MUL_SQ_Y,
		MUL_SCALE
	} mul_sel_t;

	swik_pkg::seq_state_t state_q, state_d;
	mul_sel_t mul_sel;

	logic cmd_acc, cfg_acc;
	logic ram_re, held_we, out_load, cordic_start, sqrt_start;
	logic cordic_busy, sqrt_busy;
	logic last_mod, sub_mod, vec_zero, off_we;

	logic [swik_pkg::MOD_IDX_W-1:0] k_q;
	logic [swik_pkg::MOD_DEPTH-1:0] off_vld_q, held_vld_q;
	logic [swik_pkg::SCALE_W-1:0]   scale_q;

	logic signed [swik_pkg::VEL_W-1:0] vx_q, vy_q, w_q;
	logic [swik_pkg::OFFS_W-1:0]  off_rdata, off_rd, off_q;
	logic [swik_pkg::ANGLE_W-1:0] held_rdata, held_rd, held_q, held_new;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, prod_q;
	logic signed [swik_pkg::VEC_W-1:0] mx_q, my_q, vx_sc, vy_sc, mx_d, my_d;
	logic [swik_pkg::RAD_W-1:0]  sum_q;
	logic [swik_pkg::ROOT_W-1:0] mag;
	logic [15:0] heading, d16;

	logic signed [16:0] d17, turn_d;
	logic turn_flip, flip_q;

	logic [47:0] spd_rnd;
	logic signed [18:0] spd_s;
	logic signed [swik_pkg::SPEED_W:0] spd_w;
	logic signed [swik_pkg::SPEED_W-1:0] spd_sat, spd_q;
	logic [swik_pkg::ANGLE_W-1:0] ang_q;

	logic res_vld_q, res_last_q;
	logic [swik_pkg::MOD_IDX_W-1:0] res_idx_q;
	logic signed [swik_pkg::SPEED_W-1:0] res_spd_q;
	logic [swik_pkg::ANGLE_W-1:0] res_ang_q;

	// ---------------------------------------------------------------- handshakes
	assign cmd.ready = (state_q == swik_pkg::S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign off_we    = cfg_acc && (cfg.index inside
		{[swik_pkg::REG_MODULE0_OFFSET:swik_pkg::REG_MODULE3_OFFSET]});

	assign res.valid        = res_vld_q;
	assign res.module_index = res_idx_q;
	assign res.drive_speed  = res_spd_q;
	assign res.steer_angle  = res_ang_q;
	assign res.last         = res_last_q;

	// ---------------------------------------------------------------- memories
	swik_ram #(.WIDTH(swik_pkg::OFFS_W), .DEPTH(swik_pkg::MOD_DEPTH)) u_off_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (cfg.index[swik_pkg::MOD_IDX_W-1:0]),
		.wdata (cfg.data),
		.re    (ram_re),
		.raddr (k_q),
		.rdata (off_rdata)
	);

	swik_ram #(.WIDTH(swik_pkg::ANGLE_W), .DEPTH(swik_pkg::MOD_DEPTH)) u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (k_q),
		.wdata (held_new),
		.re    (ram_re),
		.raddr (k_q),
		.rdata (held_rdata)
	);

	// never-written entries read as their reset value of zero
	assign off_rd  = off_vld_q[k_q]  ? off_rdata  : '0;
	assign held_rd = held_vld_q[k_q] ? held_rdata : '0;

	// ---------------------------------------------------------------- units
	swik_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.x_in    (mx_q),
		.y_in    (my_q),
		.busy    (cordic_busy),
		.heading (heading)
	);

	swik_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.busy     (sqrt_busy),
		.root     (mag)
	);

	// ---------------------------------------------------------------- shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mul_sel)
			MUL_YAW_X: begin
				mul_a = 32'(w_q);
				mul_b = 32'($signed(off_rd[15:0]));
			end
			MUL_YAW_Y: begin
				mul_a = 32'(w_q);
				mul_b = 32'($signed(off_q[31:16]));
			end
			MUL_SQ_X: begin
				mul_a = mx_q;
				mul_b = mx_q;
			end
			MUL_SQ_Y: begin
				mul_a = my_q;
				mul_b = my_q;
			end
			MUL_SCALE: begin
				mul_a = $signed({1'b0, mag[swik_pkg::ROOT_W-2:0]});
				mul_b = $signed({16'b0, scale_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---------------------------------------------------------------- module vector
	assign last_mod = (k_q == swik_pkg::LAST_MOD);
	assign sub_mod  = (k_q == swik_pkg::YAW_SUB_MOD_A) || (k_q == swik_pkg::YAW_SUB_MOD_B);
	assign vx_sc    = {{4{vx_q[swik_pkg::VEL_W-1]}}, vx_q, 12'b0};
	assign vy_sc    = {{4{vy_q[swik_pkg::VEL_W-1]}}, vy_q, 12'b0};
	assign mx_d     = sub_mod ? vx_sc - prod_q[31:0] : vx_sc + prod_q[31:0];
	assign my_d     = sub_mod ? vy_sc - prod_q[31:0] : vy_sc + prod_q[31:0];
	assign vec_zero = (mx_q == '0) && (my_q == '0);

	// ---------------------------------------------------------------- turn rule
	assign d16 = heading - held_q[15:0];
	assign d17 = $signed({d16[15], d16});

	always_comb begin
		turn_d    = d17;
		turn_flip = 1'b0;
		if (d17 >= swik_pkg::QUARTER_TURN) begin
			turn_d    = d17 - swik_pkg::HALF_TURN;
			turn_flip = 1'b1;
		end else if (d17 <= -swik_pkg::QUARTER_TURN) begin
			turn_d    = d17 + swik_pkg::HALF_TURN;
			turn_flip = 1'b1;
		end
	end

	assign held_new = held_q + {{(swik_pkg::ANGLE_W - 17){turn_d[16]}}, turn_d};

	// ---------------------------------------------------------------- speed
	assign spd_rnd = prod_q[47:0] + swik_pkg::SPD_ROUND;
	assign spd_s   = flip_q ? -$signed({1'b0, spd_rnd[47:30]}) : $signed({1'b0, spd_rnd[47:30]});

	always_comb begin
		spd_w = {{(swik_pkg::SPEED_W - 18){spd_s[18]}}, spd_s};
		if (spd_w > swik_pkg::SPD_MAX) begin
			spd_w = swik_pkg::SPD_MAX;
		end else if (spd_w < swik_pkg::SPD_MIN) begin
			spd_w = swik_pkg::SPD_MIN;
		end
		spd_sat = spd_w[swik_pkg::SPEED_W-1:0];
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swik_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mul_sel      = MUL_NONE;
		ram_re       = 1'b0;
		held_we      = 1'b0;
		out_load     = 1'b0;
		cordic_start = 1'b0;
		sqrt_start   = 1'b0;
		case (state_q)
			swik_pkg::S_IDLE: begin
				if (cmd.valid) begin
					state_d = swik_pkg::S_READ;
				end
			end
			swik_pkg::S_READ: begin
				ram_re  = 1'b1;
				state_d = swik_pkg::S_MULX;
			end
			swik_pkg::S_MULX: begin
				mul_sel = MUL_YAW_X;
				state_d = swik_pkg::S_MULY;
			end
			swik_pkg::S_MULY: begin
				mul_sel = MUL_YAW_Y;
				state_d = swik_pkg::S_SQX;
			end
			swik_pkg::S_SQX: begin
				mul_sel = MUL_SQ_X;
				state_d = swik_pkg::S_SQY;
			end
			swik_pkg::S_SQY: begin
				mul_sel = MUL_SQ_Y;
				if (vec_zero) begin
					state_d = swik_pkg::S_OUT;
				end else begin
					cordic_start = 1'b1;
					state_d      = swik_pkg::S_SUM;
				end
			end
			swik_pkg::S_SUM: begin
				state_d = swik_pkg::S_SQRT;
			end
			swik_pkg::S_SQRT: begin
				sqrt_start = 1'b1;
				state_d    = swik_pkg::S_WAIT;
			end
			swik_pkg::S_WAIT: begin
				if (!cordic_busy && !sqrt_busy) begin
					state_d = swik_pkg::S_SCALE;
				end
			end
			swik_pkg::S_SCALE: begin
				mul_sel = MUL_SCALE;
				held_we = 1'b1;
				state_d = swik_pkg::S_TURN;
			end
			swik_pkg::S_TURN: begin
				state_d = swik_pkg::S_OUT;
			end
			swik_pkg::S_OUT: begin
				if (!res_vld_q || res.ready) begin
					out_load = 1'b1;
					state_d  = last_mod ? swik_pkg::S_IDLE : swik_pkg::S_READ;
				end
			end
			default: begin
				state_d = swik_pkg::S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			off_vld_q  <= '0;
			held_vld_q <= '0;
			scale_q    <= swik_pkg::SPEED_SCALE_RESET;
			res_vld_q  <= 1'b0;
		end else begin
			if (cmd_acc) begin
				k_q <= '0;
			end else if (out_load && !last_mod) begin
				k_q <= k_q + 1'b1;
			end
			if (off_we) begin
				off_vld_q[cfg.index[swik_pkg::MOD_IDX_W-1:0]] <= 1'b1;
			end
			if (cfg_acc && (cfg.index == swik_pkg::REG_SPEED_SCALE)) begin
				scale_q <= cfg.data[swik_pkg::SCALE_W-1:0];
			end
			if (held_we) begin
				held_vld_q[k_q] <= 1'b1;
			end
			if (out_load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd_acc) begin
			vx_q <= cmd.vel_x;
			vy_q <= cmd.vel_y;
			w_q  <= cmd.yaw_rate;
		end
		case (state_q)
			swik_pkg::S_MULX: begin
				off_q  <= off_rd;
				held_q <= held_rd;
			end
			swik_pkg::S_MULY: begin
				mx_q <= mx_d;
			end
			swik_pkg::S_SQX: begin
				my_q <= my_d;
			end
			swik_pkg::S_SQY: begin
				// zero vector path keeps the held angle and gives no speed
				sum_q <= $unsigned(prod_q);
				spd_q <= '0;
				ang_q <= held_q;
			end
			swik_pkg::S_SUM: begin
				sum_q <= sum_q + $unsigned(prod_q);
			end
			swik_pkg::S_SCALE: begin
				ang_q  <= held_new;
				flip_q <= turn_flip;
			end
			swik_pkg::S_TURN: begin
				spd_q <= spd_sat;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			res_idx_q  <= k_q;
			res_spd_q  <= spd_q;
			res_ang_q  <= ang_q;
			res_last_q <= last_mod;
		end
	end

	// ---------------------------------------------------------------- assertions
	`SWIK_ASSERT_NOW(a_held_rmw_apart, clk, arst_n, held_we, !ram_re,
		"held angle write overlaps a read")
	`SWIK_ASSERT_NOW(a_units_done, clk, arst_n, state_q == swik_pkg::S_SCALE,
		!cordic_busy && !sqrt_busy, "turn taken before cordic and sqrt finished")
	`SWIK_ASSERT_NOW(a_turn_bounded, clk, arst_n, held_we,
		(turn_d >= -swik_pkg::QUARTER_TURN) && (turn_d <= swik_pkg::QUARTER_TURN),
		"steering step exceeds a quarter turn")
	`SWIK_ASSERT_NEXT(a_last_to_idle, clk, arst_n, out_load && last_mod,
		(state_q == swik_pkg::S_IDLE) && res_last_q, "last word did not end the command")

endmodule

### rtl/core/swik_ram.sv
// ----------------------------------------------------------------------------
// swik_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swik_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/swik_cordic.sv
// ----------------------------------------------------------------------------
// swik_cordic
// Vectoring CORDIC: normalizes the vector, then sixteen rotations, one a cycle.
// ----------------------------------------------------------------------------
module swik_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [swik_pkg::VEC_W-1:0] x_in,
	input  logic signed [swik_pkg::VEC_W-1:0] y_in,
	output logic                             busy,
	output logic [15:0]                      heading
);

	swik_pkg::cordic_state_t state_q, state_d;

	logic signed [swik_pkg::CRD_W-1:0] x_q, x_d, y_q, y_d;
	logic signed [swik_pkg::ACC_W-1:0] acc_q, acc_d;
	logic [3:0]                         it_q, it_d;

	logic signed [swik_pkg::CRD_W-1:0] x_ext, y_ext, ay, xs, ys;
	logic [swik_pkg::CRD_W-1:0]        mag_or;
	logic signed [swik_pkg::ACC_W-1:0] atan_v, acc_rnd;

	assign x_ext  = {{(swik_pkg::CRD_W - swik_pkg::VEC_W){x_in[swik_pkg::VEC_W-1]}}, x_in};
	assign y_ext  = {{(swik_pkg::CRD_W - swik_pkg::VEC_W){y_in[swik_pkg::VEC_W-1]}}, y_in};
	assign ay     = y_q[swik_pkg::CRD_W-1] ? -y_q : y_q;
	assign mag_or = x_q | ay;
	assign xs     = x_q >>> it_q;
	assign ys     = y_q >>> it_q;
	assign atan_v = $signed({{(swik_pkg::ACC_W - 22){1'b0}}, swik_pkg::atan_lut(it_q)});
	assign acc_rnd = acc_q + swik_pkg::ACC_ROUND;

	assign busy    = (state_q != swik_pkg::CS_IDLE);
	assign heading = acc_rnd[23:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swik_pkg::CS_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_d;
		y_q   <= y_d;
		acc_q <= acc_d;
	end

	always_comb begin
		state_d = state_q;
		x_d     = x_q;
		y_d     = y_q;
		acc_d   = acc_q;
		it_d    = it_q;
		case (state_q)
			swik_pkg::CS_IDLE: begin
				if (start) begin
					// left half plane: mirror through the origin, start half a turn on
					if (x_in < 0) begin
						x_d   = -x_ext;
						y_d   = -y_ext;
						acc_d = swik_pkg::ACC_HALF_TURN;
					end else begin
						x_d   = x_ext;
						y_d   = y_ext;
						acc_d = '0;
					end
					state_d = swik_pkg::CS_NORM;
				end
			end
			swik_pkg::CS_NORM: begin
				// double both until one reaches 2^30, several doublings at a time
				if (mag_or[swik_pkg::CRD_W-1:22] == '0) begin
					x_d = x_q <<< 8;
					y_d = y_q <<< 8;
				end else if (mag_or[swik_pkg::CRD_W-1:26] == '0) begin
					x_d = x_q <<< 4;
					y_d = y_q <<< 4;
				end else if (mag_or[swik_pkg::CRD_W-1:28] == '0) begin
					x_d = x_q <<< 2;
					y_d = y_q <<< 2;
				end else if (mag_or[swik_pkg::CRD_W-1:30] == '0) begin
					x_d = x_q <<< 1;
					y_d = y_q <<< 1;
				end else begin
					it_d    = '0;
					state_d = swik_pkg::CS_ITER;
				end
			end
			swik_pkg::CS_ITER: begin
				if (y_q > 0) begin
					x_d   = x_q + ys;
					y_d   = y_q - xs;
					acc_d = acc_q + atan_v;
				end else begin
					x_d   = x_q - ys;
					y_d   = y_q + xs;
					acc_d = acc_q - atan_v;
				end
				it_d = it_q + 4'd1;
				if (it_q == 4'(swik_pkg::CORDIC_ITERS - 1)) begin
					state_d = swik_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = swik_pkg::CS_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/swik_sqrt.sv
// ----------------------------------------------------------------------------
// swik_sqrt
// Digit-by-digit integer square root, two result bits per cycle.
// ----------------------------------------------------------------------------
module swik_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [swik_pkg::RAD_W-1:0]    radicand,
	output logic                          busy,
	output logic [swik_pkg::ROOT_W-1:0]   root
);

	logic                        busy_q;
	logic [3:0]                  cnt_q;
	logic [swik_pkg::RAD_W-1:0]  rad_q, rad_n;
	logic [swik_pkg::REM_W-1:0]  rem_q, rem_n;
	logic [swik_pkg::ROOT_W-1:0] root_q, root_n;

	assign busy = busy_q;
	assign root = root_q;

	always_comb begin
		logic [swik_pkg::REM_W+1:0] r2, trial;
		rad_n  = rad_q;
		rem_n  = rem_q;
		root_n = root_q;
		for (int j = 0; j < swik_pkg::SQRT_STEPS_PER_CYCLE; j++) begin
			r2    = {rem_n, rad_n[swik_pkg::RAD_W-1 -: 2]};
			trial = {{(swik_pkg::REM_W - swik_pkg::ROOT_W){1'b0}}, root_n, 2'b01};
			if (r2 >= trial) begin
				rem_n  = swik_pkg::REM_W'(r2 - trial);
				root_n = {root_n[swik_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_n  = r2[swik_pkg::REM_W-1:0];
				root_n = {root_n[swik_pkg::ROOT_W-2:0], 1'b0};
			end
			rad_n = {rad_n[swik_pkg::RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(swik_pkg::SQRT_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

endmodule

### test/swerve_module_inverse_kinematics_unit_tb.sv
// ----------------------------------------------------------------------------
// swerve_module_inverse_kinematics_unit_tb
// Sends chassis velocity commands into the swerve kinematics unit and checks
// every per-module word against a bit-accurate software model of the wheel
// speed, heading and flip rule. A short scripted part runs first, followed by
// random commands under several random register settings, with random gaps on
// the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module swerve_module_inverse_kinematics_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swik_pkg::*;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] yaw_rate;
	} motion_cmd_t;

	typedef struct packed {
		logic [MOD_IDX_W-1:0]      idx;
		logic signed [SPEED_W-1:0] speed;
		logic signed [ANGLE_W-1:0] angle;
		logic                      last;
	} wheel_word_t;

	typedef struct packed {
		motion_cmd_t cmd;
		logic [1:0]  reg_set;
		logic        zero_known;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swik_cmd_if cmd_ch ();
	swik_res_if res_ch ();
	swik_cfg_if cfg_ch ();

	swerve_module_inverse_kinematics_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// model state
	logic [MOD_DEPTH-1:0][OFFS_W-1:0]  wheel_offs;
	logic [SCALE_W-1:0]                wheel_scale;
	logic [MOD_DEPTH-1:0][ANGLE_W-1:0] held_steer;

	longint atan_turn [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	wheel_word_t pending_wheels[$];
	script_row_t script[$];
	int mismatch_count = 0;
	bit feed_steady = 1'b0;
	bit drain_steady = 1'b0;

	function automatic int pick_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// heading in 65536 counts per turn, vector must be nonzero
	function automatic logic [15:0] heading_of(input longint x, input longint y);
		longint acc;
		longint xs;
		longint ys;
		acc = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 8388608;
		end
		while (x < 1073741824 && (y < 0 ? -y : y) < 1073741824) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				acc += atan_turn[i];
			end else begin
				x -= ys;
				y += xs;
				acc -= atan_turn[i];
			end
		end
		return 16'((acc + 128) >>> 8);
	endfunction

	// works out the four module words of one accepted command
	task automatic accept_command(input motion_cmd_t c, input bit zero_known);
		longint mx;
		longint my;
		longint rx;
		longint ry;
		longint w;
		longint spd;
		longint unsigned ux;
		longint unsigned uy;
		longint unsigned mag;
		logic signed [15:0] diff;
		int d;
		bit flip;
		wheel_word_t word;
		w = longint'($signed(c.yaw_rate));
		for (int k = 0; k < NUM_MODULES; k++) begin
			rx = longint'($signed(wheel_offs[k][15:0]));
			ry = longint'($signed(wheel_offs[k][31:16]));
			mx = longint'($signed(c.vel_x)) * 4096;
			my = longint'($signed(c.vel_y)) * 4096;
			if (k == YAW_SUB_MOD_A || k == YAW_SUB_MOD_B) begin
				mx -= w * rx;
				my -= w * ry;
			end else begin
				mx += w * rx;
				my += w * ry;
			end
			word.idx = MOD_IDX_W'(k);
			word.last = (k == LAST_MOD);
			if (mx == 0 && my == 0) begin
				word.speed = '0;
				word.angle = held_steer[k];
			end else begin
				ux = (mx < 0) ? -mx : mx;
				uy = (my < 0) ? -my : my;
				mag = floor_root(ux * ux + uy * uy);
				spd = longint'((mag * wheel_scale + (64'd1 << 29)) >> 30);
				diff = heading_of(mx, my) - held_steer[k][15:0];
				d = diff;
				flip = 1'b0;
				// a quarter turn or more: go the short way and reverse the wheel
				if (d >= 16384) begin
					d -= 32768;
					flip = 1'b1;
				end else if (d <= -16384) begin
					d += 32768;
					flip = 1'b1;
				end
				held_steer[k] = held_steer[k] + 32'(d);
				if (flip)
					spd = -spd;
				if (spd > 8388607)
					spd = 8388607;
				if (spd < -8388608)
					spd = -8388608;
				word.speed = spd[SPEED_W-1:0];
				word.angle = held_steer[k];
			end
			if (zero_known) begin
				word.speed = '0;
				word.angle = '0;
			end
			pending_wheels.push_back(word);
		end
	endtask

	task automatic send_command(input motion_cmd_t c, input bit zero_known);
		int gap;
		gap = pick_gap(feed_steady);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.vel_x <= c.vel_x;
		cmd_ch.vel_y <= c.vel_y;
		cmd_ch.yaw_rate <= c.yaw_rate;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		accept_command(c, zero_known);
	endtask

	// stop feeding and let every outstanding word come back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx <= REG_MODULE3_OFFSET)
			wheel_offs[idx] = value;
		else if (idx == REG_SPEED_SCALE)
			wheel_scale = value[SCALE_W-1:0];
	endtask

	task automatic load_registers(input logic [MOD_DEPTH-1:0][OFFS_W-1:0] offs,
		input logic [SCALE_W-1:0] scale, input bit stray);
		for (int k = 0; k < NUM_MODULES; k++)
			write_register(REG_MODULE0_OFFSET + CFG_IDX_W'(k), offs[k]);
		write_register(REG_SPEED_SCALE, 32'(scale));
		// unmapped index must leave every register alone
		if (stray)
			write_register(REG_SPEED_SCALE + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_registers();
		logic [MOD_DEPTH-1:0][OFFS_W-1:0] offs;
		logic [SCALE_W-1:0] scale;
		logic signed [15:0] px;
		logic signed [15:0] py;
		for (int k = 0; k < NUM_MODULES; k++) begin
			case ($urandom_range(0, 3))
				0: offs[k] = $urandom;
				1: begin
					px = $urandom_range(0, 6000) - 3000;
					py = $urandom_range(0, 6000) - 3000;
					offs[k] = {py, px};
				end
				2: begin
					px = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					py = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					offs[k] = {py, px};
				end
				default: begin
					px = $urandom_range(300, 2500);
					py = $urandom_range(300, 2500);
					if (k == 2 || k == 3)
						px = -px;
					if (k == 1 || k == 3)
						py = -py;
					offs[k] = {py, px};
				end
			endcase
		end
		case ($urandom_range(0, 5))
			0: scale = '0;
			1: scale = '1;
			2: scale = SPEED_SCALE_RESET;
			default: scale = $urandom;
		endcase
		load_registers(offs, scale, $urandom_range(0, 1));
	endtask

	task automatic random_command(output motion_cmd_t c);
		int j;
		int k;
		int sgn;
		c.vel_x = $urandom;
		c.vel_y = $urandom;
		c.yaw_rate = $urandom;
		case ($urandom_range(0, 19))
			0, 1, 2: ;
			3, 4: begin
				c.vel_x = ($urandom_range(0, 4) == 0) ? 16'sh0 : c.vel_x;
				c.vel_y = '0;
				c.yaw_rate = ($urandom_range(0, 1) == 0) ? 16'sh0 : c.yaw_rate;
				if ($urandom_range(0, 1))
					c.vel_x = '0;
			end
			5, 6: begin
				c.vel_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				c.vel_y = $urandom_range(0, 2) == 0 ? 16'sh0 :
					($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
				c.yaw_rate = $urandom_range(0, 2) == 0 ? 16'sh1 :
					($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
			end
			7, 8, 9: begin
				// yaw term cancels the translation on one module
				k = $urandom_range(0, NUM_MODULES - 1);
				j = $urandom_range(1, 7) * ($urandom_range(0, 1) ? 1 : -1);
				sgn = (k == YAW_SUB_MOD_A || k == YAW_SUB_MOD_B) ? 1 : -1;
				c.yaw_rate = 16'(4096 * j);
				c.vel_x = 16'(sgn * j * int'($signed(wheel_offs[k][15:0])));
				c.vel_y = 16'(sgn * j * int'($signed(wheel_offs[k][31:16])));
			end
			default: begin
				c.vel_x = $urandom_range(0, 8192) - 4096;
				c.vel_y = $urandom_range(0, 8192) - 4096;
				c.yaw_rate = $urandom_range(0, 8192) - 4096;
			end
		endcase
	endtask

	task automatic add_row(input int vx, input int vy, input int yaw, input int reg_set,
		input bit zero_known);
		script_row_t r;
		r.cmd.vel_x = 16'(vx);
		r.cmd.vel_y = 16'(vy);
		r.cmd.yaw_rate = 16'(yaw);
		r.reg_set = 2'(reg_set);
		r.zero_known = zero_known;
		script.push_back(r);
	endtask

	// result checker
	always @(posedge clk) begin
		wheel_word_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_wheels.size() == 0) begin
				$error("unexpected word: module_index %0d drive_speed %0d steer_angle %0d",
					res_ch.module_index, res_ch.drive_speed, res_ch.steer_angle);
				mismatch_count++;
			end else begin
				want = pending_wheels.pop_front();
				if (res_ch.module_index !== want.idx) begin
					$error("module_index: expected %0d, got %0d", want.idx, res_ch.module_index);
					mismatch_count++;
				end
				if (res_ch.drive_speed !== want.speed) begin
					$error("drive_speed: expected %0d, got %0d", want.speed, res_ch.drive_speed);
					mismatch_count++;
				end
				if (res_ch.steer_angle !== want.angle) begin
					$error("steer_angle: expected %0d, got %0d", want.angle, res_ch.steer_angle);
					mismatch_count++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap(drain_steady);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		motion_cmd_t c;
		int cur_set;
		cmd_ch.valid = 1'b0;
		cmd_ch.vel_x = '0;
		cmd_ch.vel_y = '0;
		cmd_ch.yaw_rate = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		wheel_offs = '0;
		wheel_scale = SPEED_SCALE_RESET;
		held_steer = '0;
		cur_set = 0;

		// reset registers: zero offsets, reset scale of 256
		add_row(0, 0, 0, 0, 1);
		add_row(0, 0, 32767, 0, 1);
		add_row(0, 0, -32768, 0, 1);
		add_row(1024, 0, 0, 0, 0);
		add_row(0, 1024, 0, 0, 0);
		add_row(0, -1024, 0, 0, 0);
		add_row(-1024, 0, 0, 0, 0);
		add_row(1024, 1024, 0, 0, 0);
		add_row(-1024, -1024, 0, 0, 0);
		add_row(32767, 32767, 0, 0, 0);
		add_row(-32768, -32768, 0, 0, 0);
		add_row(32767, -32768, 0, 0, 0);
		add_row(-32768, 32767, 32767, 0, 0);
		// square chassis, full scale
		add_row(0, 0, 1024, 1, 0);
		add_row(0, 0, -1024, 1, 0);
		add_row(1229, 1229, 4096, 1, 0);
		add_row(32767, -32768, 32767, 1, 0);
		add_row(-32768, 32767, -32768, 1, 0);
		// offsets at the corners of their range, zero scale
		add_row(32767, 32767, 32767, 2, 0);
		add_row(-32768, -32768, -32768, 2, 0);
		add_row(0, 0, 32767, 2, 0);
		add_row(1, 0, 0, 2, 0);
		add_row(0, -1, 0, 2, 0);
		add_row(-1, 0, 0, 2, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].reg_set != cur_set) begin
				drain();
				cur_set = script[r].reg_set;
				if (cur_set == 1)
					load_registers({32'hFB33FB33, 32'h04CDFB33, 32'hFB3304CD, 32'h04CD04CD},
						16'hFFFF, 1'b0);
				else
					load_registers({32'h80007FFF, 32'h7FFF8000, 32'h7FFF7FFF, 32'h80008000},
						16'h0000, 1'b1);
			end
			send_command(script[r].cmd, script[r].zero_known);
		end

		for (int p = 0; p < 5; p++) begin
			drain();
			random_registers();
			feed_steady = ($urandom_range(0, 2) == 0);
			drain_steady = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < 42; n++) begin
				random_command(c);
				send_command(c, 1'b0);
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/swik_pkg.sv
rtl/core/swik_if.sv
rtl/core/swik_ram.sv
rtl/core/swik_cordic.sv
rtl/core/swik_sqrt.sv
rtl/core/swerve_module_inverse_kinematics_unit.sv
test/swerve_module_inverse_kinematics_unit_tb.sv
